// File: src/ibff_pkg.sv
// ============================================================================
// ibff_pkg: shared types and constants of the IPv4 blacklist and flood filter
// Holds the request formats passed between the parser, the queues and the
// verdict pipeline, plus the fixed protocol and hash constants.
// ============================================================================
`default_nettype none

package ibff_pkg;

    localparam logic [15:0] ETH_IPV4     = 16'h0800;
    localparam logic [7:0]  MIN_IP_FRAME = 8'd34;
    localparam logic [6:0]  POS_MAX      = 7'd127;
    localparam logic [7:0]  PROTO_TCP    = 8'd6;
    localparam logic [7:0]  PROTO_UDP    = 8'd17;
    localparam logic [31:0] HASH_MULT    = 32'd2654435761;
    localparam logic [19:0] ROLL_MOD     = 20'd1000000;
    // ceil(2^40 / 15625): exact quotient of a 26-bit value by 15625.
    localparam logic [26:0] ROLL_RECIP   = 27'd70368745;

    localparam logic [1:0] REG_BYPASS    = 2'd0;
    localparam logic [1:0] REG_HASH_DROP = 2'd1;
    localparam logic [1:0] REG_DROP_PROB = 2'd2;

    localparam logic COMMAND_FRAME = 1'b0;
    localparam logic COMMAND_WRITE = 1'b1;

    // One request from the parser to the verdict pipeline.
    typedef struct packed {
        logic        is_write;
        logic        wr_en;
        logic [3:0]  wr_index;
        logic [31:0] wr_address;
        logic [5:0]  wr_prefix;
        logic        wr_blocked;
        logic        wr_valid;
        logic        check;
        logic        report_ok;
        logic [15:0] ident;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] length;
        logic [7:0]  proto;
        logic [15:0] dport;
    } ibff_job_t;

    typedef struct packed {
        logic        verdict;
        logic        report_valid;
        logic [31:0] source_address;
        logic [31:0] destination_address;
        logic [15:0] total_length;
        logic [7:0]  protocol_number;
        logic [15:0] destination_port;
        logic [63:0] frames_seen;
        logic [63:0] frames_dropped;
    } ibff_res_t;

    function automatic logic [31:0] prefix_mask(input logic [5:0] plen);
        prefix_mask = ~(32'hFFFF_FFFF >> plen);
    endfunction

endpackage

`default_nettype wire

// File: src/ibff_fifo.sv
// ============================================================================
// ibff_fifo: small register queue
// Queue of any depth with wrapping pointers and a fill count; the head entry is always shown.
// ============================================================================
`default_nettype none

module ibff_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         push,
    input  wire  [WIDTH-1:0]            wdata,
    input  wire                         pop,
    output logic [WIDTH-1:0]            rdata,
    output logic                        full,
    output logic                        empty,
    output logic [$clog2(DEPTH+1)-1:0]  count
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH+1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign rdata   = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

// File: src/ibff_front.sv
// ============================================================================
// ibff_front: frame parser
// Tracks the byte position, captures the header fields as they pass and
// emits one request per blacklist write and per finished frame.
// ============================================================================
`default_nettype none

module ibff_front #(
    parameter int BLACKLIST_ENTRIES = 16
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 accept,
    input  wire                 command,
    input  wire  [7:0]          frame_byte,
    input  wire                 last_byte,
    input  wire  [3:0]          entry_index,
    input  wire  [31:0]         entry_address,
    input  wire  [5:0]          entry_prefix_length,
    input  wire                 entry_blocked,
    input  wire                 entry_valid,
    output logic                job_push,
    output ibff_pkg::ibff_job_t job
);
    import ibff_pkg::*;

    logic [6:0]  pos_reg, pos_next;
    logic [15:0] ether_reg, ether_next;
    logic [3:0]  hw_reg, hw_next;
    logic [15:0] ident_reg, ident_next;
    logic [31:0] src_reg, src_next;
    logic [31:0] dst_reg, dst_next;
    logic [15:0] length_reg, length_next;
    logic [7:0]  proto_reg, proto_next;
    logic [15:0] port_reg, port_next;
    logic [7:0]  pos8, frame_len, t_off;
    logic        frame_step, dport_ok;

    assign frame_step = accept && (command == COMMAND_FRAME);
    assign pos8       = {1'b0, pos_reg};
    assign frame_len  = pos8 + 8'd1;

    always_comb
    begin
        pos_next    = pos_reg;
        ether_next  = ether_reg;
        hw_next     = hw_reg;
        ident_next  = ident_reg;
        src_next    = src_reg;
        dst_next    = dst_reg;
        length_next = length_reg;
        proto_next  = proto_reg;
        port_next   = port_reg;
        t_off       = 8'd14 + {2'b0, hw_reg, 2'b0};
        if (frame_step)
        begin
            unique case (pos_reg)
                7'd12: ether_next  = {frame_byte, ether_reg[7:0]};
                7'd13: ether_next  = {ether_reg[15:8], frame_byte};
                7'd14: hw_next     = frame_byte[3:0];
                7'd16: length_next = {frame_byte, length_reg[7:0]};
                7'd17: length_next = {length_reg[15:8], frame_byte};
                7'd18: ident_next  = {frame_byte, ident_reg[7:0]};
                7'd19: ident_next  = {ident_reg[15:8], frame_byte};
                7'd23: proto_next  = frame_byte;
                7'd26, 7'd27, 7'd28, 7'd29: src_next = {src_reg[23:0], frame_byte};
                7'd30, 7'd31, 7'd32, 7'd33: dst_next = {dst_reg[23:0], frame_byte};
                default: ;
            endcase
            // The header length is settled once the position is past 14.
            if (pos_reg > 7'd14)
            begin
                if (pos8 == t_off + 8'd2)
                begin
                    port_next = {frame_byte, port_reg[7:0]};
                end
                else if (pos8 == t_off + 8'd3)
                begin
                    port_next = {port_reg[15:8], frame_byte};
                end
            end
            if (last_byte)
            begin
                pos_next = '0;
            end
            else if (pos_reg < POS_MAX)
            begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            ether_reg  <= '0;
            hw_reg     <= '0;
            ident_reg  <= '0;
            src_reg    <= '0;
            dst_reg    <= '0;
            length_reg <= '0;
            proto_reg  <= '0;
            port_reg   <= '0;
        end
        else
        begin
            pos_reg    <= pos_next;
            ether_reg  <= ether_next;
            hw_reg     <= hw_next;
            ident_reg  <= ident_next;
            src_reg    <= src_next;
            dst_reg    <= dst_next;
            length_reg <= length_next;
            proto_reg  <= proto_next;
            port_reg   <= port_next;
        end
    end

    logic [7:0]  t_fin;
    logic [31:0] idx_wide;

    assign t_fin    = 8'd14 + {2'b0, hw_next, 2'b0};
    assign dport_ok = ((proto_next == PROTO_TCP) && (t_fin + 8'd20 <= frame_len)) ||
                      ((proto_next == PROTO_UDP) && (t_fin + 8'd8 <= frame_len));
    assign idx_wide = {28'b0, entry_index};

    assign job_push = accept && ((command == COMMAND_WRITE) || last_byte);

    always_comb
    begin
        job            = '0;
        job.is_write   = (command == COMMAND_WRITE);
        job.wr_en      = (idx_wide < 32'(BLACKLIST_ENTRIES)) && (entry_prefix_length <= 6'd32);
        job.wr_index   = entry_index;
        job.wr_address = entry_address;
        job.wr_prefix  = entry_prefix_length;
        job.wr_blocked = entry_blocked;
        job.wr_valid   = entry_valid;
        job.check      = (frame_len >= MIN_IP_FRAME) && (ether_next == ETH_IPV4);
        job.report_ok  = (hw_next >= 4'd5) && (t_fin <= frame_len);
        job.ident      = ident_next;
        job.src_addr   = src_next;
        job.dst_addr   = dst_next;
        job.length     = length_next;
        job.proto      = proto_next;
        job.dport      = dport_ok ? port_next : 16'd0;
    end

endmodule

`default_nettype wire

// File: src/ibff_back.sv
// ============================================================================
// ibff_back: verdict pipeline
// Four stages: blacklist write, prefix compare and hash product, longest-match
// tree and reciprocal quotient, hash remainder, then verdict and counters.
// ============================================================================
`default_nettype none

module ibff_back #(
    parameter int BLACKLIST_ENTRIES = 16,
    parameter int OUT_DEPTH         = 8
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            job_empty,
    input  ibff_pkg::ibff_job_t            job,
    output logic                           job_pop,
    input  wire  [$clog2(OUT_DEPTH+1)-1:0] out_count,
    input  wire                            bypass,
    input  wire                            hash_drop_en,
    input  wire  [19:0]                    drop_probability,
    output logic                           res_push,
    output ibff_pkg::ibff_res_t            res
);
    import ibff_pkg::*;

    localparam int N  = BLACKLIST_ENTRIES;
    localparam int IW = (N > 1) ? $clog2(N) : 1;
    localparam int P  = 1 << $clog2(N);
    localparam int CW = $clog2(OUT_DEPTH+1);

    logic            v1_reg, v2_reg, v3_reg, v4_reg;
    ibff_job_t       j1_reg, j2_reg, j3_reg, j4_reg;
    logic [CW:0]     pending;

    assign pending = {1'b0, out_count} + (CW+1)'(v1_reg) + (CW+1)'(v2_reg)
                   + (CW+1)'(v3_reg) + (CW+1)'(v4_reg);
    // A request only enters when the result queue is sure to have room.
    assign job_pop = !job_empty && (pending < (CW+1)'(OUT_DEPTH));

    // ---------------- stage 1: table write, compare, hash product
    logic [31:0] bl_addr_reg [N];
    logic [5:0]  bl_pref_reg [N];
    logic        bl_blk_reg  [N];
    logic [N-1:0] bl_valid_reg;
    logic [N-1:0] hit1;
    logic [31:0] wr_idx32;
    logic [IW-1:0] wr_idx;
    logic        wr_go;
    logic [15:0] hash_x;
    logic [47:0] hash_prod;

    assign wr_idx32  = {28'b0, j1_reg.wr_index};
    assign wr_idx    = wr_idx32[IW-1:0];
    assign wr_go     = v1_reg && j1_reg.is_write && j1_reg.wr_en;
    assign hash_x    = j1_reg.ident ^ {j1_reg.src_addr[23:16], j1_reg.src_addr[31:24]};
    assign hash_prod = {32'b0, hash_x} * {16'b0, HASH_MULT};

    always_comb
    begin
        for (int k = 0; k < N; k++)
        begin
            hit1[k] = bl_valid_reg[k] &&
                      (((j1_reg.src_addr ^ bl_addr_reg[k]) & prefix_mask(bl_pref_reg[k]))
                       == 32'd0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bl_valid_reg <= '0;
        end
        else if (wr_go)
        begin
            bl_valid_reg[wr_idx] <= j1_reg.wr_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_go)
        begin
            bl_addr_reg[wr_idx] <= j1_reg.wr_address;
            bl_pref_reg[wr_idx] <= j1_reg.wr_prefix;
            bl_blk_reg[wr_idx]  <= j1_reg.wr_blocked;
        end
    end

    logic [N-1:0] hit2_reg;
    logic [5:0]   len2_reg [N];
    logic         blk2_reg [N];
    logic [31:0]  h2_reg;

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < N; k++)
        begin
            len2_reg[k] <= bl_pref_reg[k];
            blk2_reg[k] <= bl_blk_reg[k];
        end
        hit2_reg <= hit1;
        h2_reg   <= hash_prod[31:0];
    end

    // ---------------- stage 2: longest-match tree, quotient by 10^6
    logic        nd_hit [2*P-1:1];
    logic [5:0]  nd_len [2*P-1:1];
    logic        nd_blk [2*P-1:1];
    logic [52:0] q_prod;

    always_comb
    begin
        for (int k = 0; k < P; k++)
        begin
            if (k < N)
            begin
                nd_hit[P+k] = hit2_reg[k];
                nd_len[P+k] = len2_reg[k];
                nd_blk[P+k] = blk2_reg[k];
            end
            else
            begin
                nd_hit[P+k] = 1'b0;
                nd_len[P+k] = '0;
                nd_blk[P+k] = 1'b0;
            end
        end
        // The lower slot wins ties, so the right child needs a strictly longer prefix.
        for (int i = P-1; i >= 1; i--)
        begin
            if (nd_hit[2*i+1] && (!nd_hit[2*i] || (nd_len[2*i+1] > nd_len[2*i])))
            begin
                nd_hit[i] = 1'b1;
                nd_len[i] = nd_len[2*i+1];
                nd_blk[i] = nd_blk[2*i+1];
            end
            else
            begin
                nd_hit[i] = nd_hit[2*i];
                nd_len[i] = nd_len[2*i];
                nd_blk[i] = nd_blk[2*i];
            end
        end
    end

    assign q_prod = {27'b0, h2_reg[31:6]} * {26'b0, ROLL_RECIP};

    logic        blk3_reg;
    logic [31:0] h3_reg;
    logic [12:0] q3_reg;

    always_ff @(posedge clk)
    begin
        blk3_reg <= nd_hit[1] && nd_blk[1];
        h3_reg   <= h2_reg;
        q3_reg   <= q_prod[52:40];
    end

    // ---------------- stage 3: remainder
    logic [32:0] qm;
    logic [32:0] rem;
    logic        blk4_reg;
    logic [19:0] r4_reg;

    assign qm  = {20'b0, q3_reg} * {13'b0, ROLL_MOD};
    assign rem = {1'b0, h3_reg} - qm;

    always_ff @(posedge clk)
    begin
        blk4_reg <= blk3_reg;
        r4_reg   <= rem[19:0];
    end

    // ---------------- stage 4: verdict and counters
    logic [63:0] seen_reg, seen_next;
    logic [63:0] drop_reg, drop_next;
    logic        chk4, drop4, rpt4;

    assign chk4  = !bypass && j4_reg.check;
    assign drop4 = chk4 && (blk4_reg ||
                   (hash_drop_en && (drop_probability != 20'd0) && (r4_reg < drop_probability)));
    assign rpt4  = chk4 && !drop4 && j4_reg.report_ok;

    assign res_push  = v4_reg && !j4_reg.is_write;
    assign seen_next = res_push ? seen_reg + 64'd1 : seen_reg;
    assign drop_next = (res_push && drop4) ? drop_reg + 64'd1 : drop_reg;

    always_comb
    begin
        res                     = '0;
        res.verdict             = drop4;
        res.report_valid        = rpt4;
        res.source_address      = rpt4 ? j4_reg.src_addr : 32'd0;
        res.destination_address = rpt4 ? j4_reg.dst_addr : 32'd0;
        res.total_length        = rpt4 ? j4_reg.length : 16'd0;
        res.protocol_number     = rpt4 ? j4_reg.proto : 8'd0;
        res.destination_port    = rpt4 ? j4_reg.dport : 16'd0;
        res.frames_seen         = seen_next;
        res.frames_dropped      = drop_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            seen_reg <= '0;
            drop_reg <= '0;
        end
        else
        begin
            v1_reg   <= job_pop;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            seen_reg <= seen_next;
            drop_reg <= drop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        j1_reg <= job;
        j2_reg <= j1_reg;
        j3_reg <= j2_reg;
        j4_reg <= j3_reg;
    end

    a_room: assert property (@(posedge clk) disable iff (!rst_n)
        pending <= (CW+1)'(OUT_DEPTH))
        else $error("results in flight exceed result queue room");

    a_drop_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (drop_reg != $past(drop_reg)) |-> (seen_reg != $past(seen_reg)))
        else $error("drop counter moved without a frame");

    a_drop_no_report: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res.verdict) |-> !res.report_valid)
        else $error("dropped frame carries a report");

    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (v4_reg && j4_reg.is_write) |=> (seen_reg == $past(seen_reg)))
        else $error("blacklist write counted as a frame");

endmodule

`default_nettype wire

// File: src/ipv4_blacklist_flood_filter.sv
// ============================================================================
// ipv4_blacklist_flood_filter: IPv4 source filter with blacklist and flood drop
// Parser front end, request queue, verdict pipeline and result queue.
// ============================================================================
// Frame bytes and blacklist writes are taken one per clock as long as full is
// low; full rises only when the four-entry request queue between the parser
// and the verdict pipeline is backed up. Each frame gives one verdict entry in
// the result queue once its request has left the request queue and passed the
// four pipeline stages: prefix compare, longest-match tree with the hash
// quotient, hash remainder, verdict and counters. A blacklist write takes
// effect for every frame whose last byte is pushed after it. Sustained rate is
// one byte or write per clock while full is low; pipeline entry is held off
// while result queue entries plus requests in flight fill the eight-entry queue.
`default_nettype none

module ipv4_blacklist_flood_filter #(
    parameter int BLACKLIST_ENTRIES = 16
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         push,
    output logic        full,
    input  wire         command,
    input  wire  [7:0]  frame_byte,
    input  wire         last_byte,
    input  wire  [3:0]  entry_index,
    input  wire  [31:0] entry_address,
    input  wire  [5:0]  entry_prefix_length,
    input  wire         entry_blocked,
    input  wire         entry_valid,
    output logic        empty,
    input  wire         pop,
    output logic        verdict,
    output logic        report_valid,
    output logic [31:0] source_address,
    output logic [31:0] destination_address,
    output logic [15:0] total_length,
    output logic [7:0]  protocol_number,
    output logic [15:0] destination_port,
    output logic [63:0] frames_seen,
    output logic [63:0] frames_dropped,
    input  wire         write_enable,
    input  wire  [1:0]  register_index,
    input  wire  [19:0] write_data
);
    import ibff_pkg::*;

    localparam int JOB_DEPTH = 4;
    localparam int OUT_DEPTH = 8;

    logic        bypass_reg;
    logic        flood_reg;
    logic [19:0] dprob_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bypass_reg <= 1'b0;
            flood_reg  <= 1'b0;
            dprob_reg  <= '0;
        end
        else if (write_enable)
        begin
            unique case (register_index)
                REG_BYPASS:    bypass_reg <= write_data[0];
                REG_HASH_DROP: flood_reg  <= write_data[0];
                REG_DROP_PROB: dprob_reg  <= write_data;
                default: ;
            endcase
        end
    end

    logic      in_accept;
    logic      job_push, job_pop, job_empty, job_full;
    ibff_job_t job_in, job_out;
    logic [$clog2(JOB_DEPTH+1)-1:0] job_count;

    assign full      = job_full;
    assign in_accept = push && !job_full;

    ibff_front #(
        .BLACKLIST_ENTRIES(BLACKLIST_ENTRIES)
    ) u_front (
        .clk                 (clk),
        .rst_n               (rst_n),
        .accept              (in_accept),
        .command             (command),
        .frame_byte          (frame_byte),
        .last_byte           (last_byte),
        .entry_index         (entry_index),
        .entry_address       (entry_address),
        .entry_prefix_length (entry_prefix_length),
        .entry_blocked       (entry_blocked),
        .entry_valid         (entry_valid),
        .job_push            (job_push),
        .job                 (job_in)
    );

    ibff_fifo #(
        .WIDTH($bits(ibff_job_t)),
        .DEPTH(JOB_DEPTH)
    ) u_job_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_push),
        .wdata (job_in),
        .pop   (job_pop),
        .rdata (job_out),
        .full  (job_full),
        .empty (job_empty),
        .count (job_count)
    );

    logic      res_push, res_full;
    ibff_res_t res_in, res_out;
    logic [$clog2(OUT_DEPTH+1)-1:0] res_count;

    ibff_back #(
        .BLACKLIST_ENTRIES(BLACKLIST_ENTRIES),
        .OUT_DEPTH        (OUT_DEPTH)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .job_empty        (job_empty),
        .job              (job_out),
        .job_pop          (job_pop),
        .out_count        (res_count),
        .bypass           (bypass_reg),
        .hash_drop_en     (flood_reg),
        .drop_probability (dprob_reg),
        .res_push         (res_push),
        .res              (res_in)
    );

    ibff_fifo #(
        .WIDTH($bits(ibff_res_t)),
        .DEPTH(OUT_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_in),
        .pop   (pop),
        .rdata (res_out),
        .full  (res_full),
        .empty (empty),
        .count (res_count)
    );

    assign verdict             = res_out.verdict;
    assign report_valid        = res_out.report_valid;
    assign source_address      = res_out.source_address;
    assign destination_address = res_out.destination_address;
    assign total_length        = res_out.total_length;
    assign protocol_number     = res_out.protocol_number;
    assign destination_port    = res_out.destination_port;
    assign frames_seen         = res_out.frames_seen;
    assign frames_dropped      = res_out.frames_dropped;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("verdict pushed into a full result queue");

    a_job_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (job_push && !job_full && !job_pop) |=> (job_count == $past(job_count) + 1'b1))
        else $error("request lost between parser and pipeline");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        job_count <= JOB_DEPTH)
        else $error("request queue count out of range");

endmodule

`default_nettype wire
